@@ hw/rtl/mpgr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpgr_pkg
// Shared constants and command/status types for the max pool gradient block.
// ----------------------------------------------------------------------------
package mpgr_pkg;
  localparam int MAX_WIDTH    = 32;
  localparam int MAX_HEIGHT   = 32;
  localparam int MAX_CHANNELS = 4;
  localparam int MAX_WINDOW   = 4;
  localparam int SAMPLE_BITS  = 16;
  localparam int GRAD_BITS    = SAMPLE_BITS + 4;
  localparam int CB = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(MAX_HEIGHT);
  localparam int HB = $clog2(MAX_CHANNELS);
  localparam int KB = $clog2(MAX_WINDOW);
  localparam int CELL_BITS = HB + RB + CB;

  localparam logic [1:0] FUNC_FWD  = 2'd0;
  localparam logic [1:0] FUNC_GRAD = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;

  localparam logic [2:0] REG_WIDTH  = 3'd0;
  localparam logic [2:0] REG_HEIGHT = 3'd1;
  localparam logic [2:0] REG_CHAN   = 3'd2;
  localparam logic [2:0] REG_WIN    = 3'd3;
  localparam logic [2:0] REG_STEP   = 3'd4;

  typedef struct packed {
    logic start;        // latch request, set up first scan
    logic scan_step;    // process one window column candidate
    logic grad_read;    // issue winner read
    logic grad_write;   // write saturated sum
    logic read_out;     // read sum for readout
    logic read_clear;   // emit readout and clear
    logic clear_step;   // reset clearing pass
  } cmd_t;

  typedef struct packed {
    logic       no_windows;
    logic       scan_done;
    logic       clear_done;
  } stat_t;
endpackage
`default_nettype wire

@@ hw/rtl/mpgr_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpgr_datapath
// Counters, window maxima, winner and gradient memories, result register.
// ----------------------------------------------------------------------------
module mpgr_datapath (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire mpgr_pkg::cmd_t         cmd,
  output mpgr_pkg::stat_t             stat,
  input  wire logic                   cfg_write,
  input  wire logic [2:0]             cfg_index,
  input  wire logic [5:0]             cfg_data,
  input  wire logic [1:0]             func,
  input  wire logic signed [15:0]     sample,
  output logic                        res_valid,
  input  wire logic                   res_take,
  output logic                        kind,
  output logic [1:0]                  channel,
  output logic [4:0]                  row,
  output logic [4:0]                  col,
  output logic signed [19:0]          value,
  output logic                        last
);
  import mpgr_pkg::*;

  localparam int SLOTS = MAX_WINDOW * MAX_WIDTH;
  localparam int CELLS = MAX_CHANNELS * MAX_WIDTH * MAX_HEIGHT;

  logic [5:0] reg_w, reg_h;
  logic [2:0] reg_c, reg_k, reg_s;
  logic [CB:0] w_c;
  logic [RB:0] h_c;
  logic [HB:0] c_c;
  logic [KB:0] k_c, s_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      reg_w <= 6'd32; reg_h <= 6'd32; reg_c <= 3'd4; reg_k <= 3'd2; reg_s <= 3'd2;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_WIDTH:  reg_w <= cfg_data;
        REG_HEIGHT: reg_h <= cfg_data;
        REG_CHAN:   reg_c <= cfg_data[2:0];
        REG_WIN:    reg_k <= cfg_data[2:0];
        REG_STEP:   reg_s <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    w_c = (reg_w == 6'd0) ? (CB+1)'(1) : (reg_w > 6'(MAX_WIDTH)) ? (CB+1)'(MAX_WIDTH)
        : reg_w[CB:0];
    h_c = (reg_h == 6'd0) ? (RB+1)'(1) : (reg_h > 6'(MAX_HEIGHT)) ? (RB+1)'(MAX_HEIGHT)
        : reg_h[RB:0];
    c_c = (reg_c == 3'd0) ? (HB+1)'(1) : (reg_c > 3'(MAX_CHANNELS)) ?
          (HB+1)'(MAX_CHANNELS) : reg_c[HB:0];
    k_c = (reg_k == 3'd0) ? (KB+1)'(1) : (reg_k > 3'(MAX_WINDOW)) ? (KB+1)'(MAX_WINDOW)
        : reg_k[KB:0];
    s_c = (reg_s == 3'd0) ? (KB+1)'(1) : (reg_s > 3'(MAX_WINDOW)) ? (KB+1)'(MAX_WINDOW)
        : reg_s[KB:0];
  end

  // windows per direction: (map - K) / S + 1, zero when the window does not fit;
  // divide by three as span*11/32, exact for spans below 32
  function automatic logic [CB:0] pooled_dim(input logic [CB:0] m, input logic [KB:0] k,
                                             input logic [KB:0] s);
    logic [CB:0]   span;
    logic [CB+4:0] third;
    logic [CB:0]   quot;
    span = m - (CB+1)'(k);
    third = (CB+5)'(span) * (CB+5)'(11);
    case (s)
      (KB+1)'(1): quot = span;
      (KB+1)'(2): quot = span >> 1;
      (KB+1)'(3): quot = {1'b0, third[CB+4:5]};
      default:    quot = span >> 2;
    endcase
    if ((CB+1)'(k) > m) return '0;
    return quot + 1'b1;
  endfunction

  logic [CB:0] ow;
  logic [RB:0] oh;
  assign ow = pooled_dim(w_c, k_c, s_c);
  assign oh = (RB+1)'(pooled_dim((CB+1)'(h_c), k_c, s_c));

  // pass counters as (channel,row,col) tuples
  logic [HB-1:0] f_ch, b_ch, r_ch;
  logic [RB-1:0] f_r, r_r, b_i;
  logic [CB-1:0] f_c, r_c, b_j;

  // latched request
  logic signed [15:0] v_q;
  logic [1:0] func_q;
  logic [HB-1:0] ch_q;
  logic [RB-1:0] r_q;
  logic [CB-1:0] c_q;
  logic [CB:0]   j_w;       // candidate window column index
  logic [CB+1:0] j_base;    // j*S
  logic [RB:0]   i_w;
  logic [RB+1:0] i_base;
  logic          row_hit;

  logic signed [15:0] pm_val [SLOTS];
  logic [CB+RB-1:0]   pm_pos [SLOTS];
  logic [CB+RB-1:0]   win_pos [CELLS];
  logic signed [19:0] gsum [CELLS];
  logic               res_full;
  logic [CELL_BITS-1:0] clr_addr;
  logic                 clr_done;

  // window candidates are walked row by row, columns left to right; a candidate
  // whose window holds the sample is handled in two steps: read the partial max, then
  // compare and write back
  logic [KB-1:0] slot_row;
  logic [$clog2(SLOTS)-1:0] slot;
  logic signed [15:0] cur_v;
  logic [CB+RB-1:0] cur_p, here;
  logic first_s, last_s, take, col_hit, hit, scan_phase, scan_go;

  assign here = {r_q, c_q};
  assign slot_row = i_w[KB-1:0];
  assign slot = {slot_row, j_w[CB-1:0]};
  assign col_hit = (j_base <= (CB+2)'(c_q)) && ((CB+2)'(c_q) < j_base + (CB+2)'(k_c))
                   && (j_w < ow);
  assign row_hit = (i_base <= (RB+2)'(r_q)) && ((RB+2)'(r_q) < i_base + (RB+2)'(k_c))
                   && (i_w < oh);
  assign hit = row_hit && col_hit;
  assign scan_go = cmd.scan_step && (scan_phase || !hit);
  assign first_s = (i_base == (RB+2)'(r_q)) && (j_base == (CB+2)'(c_q));
  assign last_s  = (i_base + (RB+2)'(k_c) - 1'b1 == (RB+2)'(r_q)) &&
                   (j_base + (CB+2)'(k_c) - 1'b1 == (CB+2)'(c_q));
  assign take = first_s || (v_q > cur_v) || (v_q == cur_v && c_q < cur_p[CB-1:0]);

  // gradient path
  logic signed [19:0] g_old;
  logic [CB+RB-1:0] wp_q;
  logic signed [20:0] g_sum;
  assign g_sum = 21'(g_old) + 21'(v_q);

  always_ff @(posedge clk) begin
    if (cmd.scan_step && !scan_phase) begin
      cur_v <= pm_val[slot];
      cur_p <= pm_pos[slot];
    end
    if (scan_go && hit) begin
      if (take) begin
        pm_val[slot] <= v_q;
        pm_pos[slot] <= here;
      end
      if (last_s)
        win_pos[{ch_q, i_w[RB-1:0], j_w[CB-1:0]}] <= take ? here : cur_p;
    end
    if (cmd.grad_read) wp_q <= win_pos[{b_ch, b_i, b_j}];
    if (cmd.read_out) g_old <= gsum[{r_ch, r_r, r_c}];
    else if (cmd.grad_write == 1'b0 && func_q == FUNC_GRAD) g_old <= gsum[{b_ch, wp_q}];
    if (cmd.clear_step) gsum[clr_addr] <= '0;
    else if (cmd.grad_write)
      gsum[{b_ch, wp_q}] <= (g_sum > 21'sh7FFFF) ? 20'sh7FFFF :
                           (g_sum < -21'sh80000) ? 20'sh80000 : g_sum[19:0];
    else if (cmd.read_clear) gsum[{r_ch, r_r, r_c}] <= '0;
  end

  logic f_wrap, b_wrap, r_wrap;
  assign f_wrap = ({1'b0,f_c} + 1'b1 >= w_c) && ({1'b0,f_r} + 1'b1 >= h_c) &&
                  ({1'b0,f_ch} + 1'b1 >= c_c);
  assign r_wrap = ({1'b0,r_c} + 1'b1 >= w_c) && ({1'b0,r_r} + 1'b1 >= h_c) &&
                  ({1'b0,r_ch} + 1'b1 >= c_c);
  assign b_wrap = ({1'b0,b_j} + 1'b1 >= ow) && ({1'b0,b_i} + 1'b1 >= oh) &&
                  ({1'b0,b_ch} + 1'b1 >= c_c);

  always_ff @(posedge clk) begin
    if (rst) begin
      f_ch <= '0; f_r <= '0; f_c <= '0; b_ch <= '0; b_i <= '0; b_j <= '0;
      r_ch <= '0; r_r <= '0; r_c <= '0; res_full <= 1'b0; func_q <= FUNC_READ;
      clr_addr <= '0; clr_done <= 1'b0; scan_phase <= 1'b0;
    end else begin
      if (cmd.clear_step) begin
        clr_addr <= clr_addr + 1'b1;
        if (&clr_addr) clr_done <= 1'b1;
      end
      if (res_take) res_full <= 1'b0;
      if (cfg_write && cfg_index <= REG_STEP) begin
        f_ch <= '0; f_r <= '0; f_c <= '0; b_ch <= '0; b_i <= '0; b_j <= '0;
        r_ch <= '0; r_r <= '0; r_c <= '0;
      end
      if (cmd.start) scan_phase <= 1'b0;
      else if (cmd.scan_step) scan_phase <= !scan_phase && hit;
      if (cmd.start) begin
        func_q <= func; v_q <= sample;
        ch_q <= f_ch; r_q <= f_r; c_q <= f_c;
        i_w <= '0; i_base <= '0; j_w <= '0; j_base <= '0;
        if (func == FUNC_FWD) begin
          if (f_wrap) begin
            f_ch <= '0; f_r <= '0; f_c <= '0;
          end else if ({1'b0,f_c} + 1'b1 >= w_c) begin
            f_c <= '0;
            if ({1'b0,f_r} + 1'b1 >= h_c) begin f_r <= '0; f_ch <= f_ch + 1'b1; end
            else f_r <= f_r + 1'b1;
          end else f_c <= f_c + 1'b1;
        end
      end
      if (scan_go) begin
        if (hit && last_s) begin
          res_full <= 1'b1; kind <= 1'b0; channel <= 2'(ch_q);
          row <= 5'(take ? r_q : cur_p[CB+RB-1:CB]);
          col <= 5'(take ? c_q : cur_p[CB-1:0]);
          value <= 20'(take ? v_q : cur_v);
          last <= ({1'b0,ch_q} + 1'b1 == c_c) && (i_w + 1'b1 == oh) && (j_w + 1'b1 == ow);
        end
        if (j_w + 1'b1 >= ow || j_base + (CB+2)'(s_c) > (CB+2)'(c_q)) begin
          j_w <= '0; j_base <= '0; i_w <= i_w + 1'b1; i_base <= i_base + (RB+2)'(s_c);
        end else begin
          j_w <= j_w + 1'b1; j_base <= j_base + (CB+2)'(s_c);
        end
      end
      if (cmd.grad_write) begin
        if (b_wrap) begin b_ch <= '0; b_i <= '0; b_j <= '0; end
        else if ({1'b0,b_j} + 1'b1 >= ow) begin
          b_j <= '0;
          if ({1'b0,b_i} + 1'b1 >= oh) begin b_i <= '0; b_ch <= b_ch + 1'b1; end
          else b_i <= b_i + 1'b1;
        end else b_j <= b_j + 1'b1;
      end
      if (cmd.read_clear) begin
        res_full <= 1'b1; kind <= 1'b1; channel <= 2'(r_ch); row <= 5'(r_r);
        col <= 5'(r_c); value <= g_old; last <= r_wrap;
        if (r_wrap) begin r_ch <= '0; r_r <= '0; r_c <= '0; end
        else if ({1'b0,r_c} + 1'b1 >= w_c) begin
          r_c <= '0;
          if ({1'b0,r_r} + 1'b1 >= h_c) begin r_r <= '0; r_ch <= r_ch + 1'b1; end
          else r_r <= r_r + 1'b1;
        end else r_c <= r_c + 1'b1;
      end
    end
  end

  assign res_valid = res_full;
  assign stat.no_windows = (ow == '0) || (oh == '0);
  assign stat.scan_done = (i_w >= oh) || (i_base > (RB+2)'(r_q));
  assign stat.clear_done = clr_done;
endmodule
`default_nettype wire

@@ hw/rtl/mpgr_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// mpgr_ctrl
// Sequencer for forward scan, gradient update, readout and reset clearing.
// ----------------------------------------------------------------------------
module mpgr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_func,
  output logic                  in_ready,
  input  wire logic             res_full,
  input  wire mpgr_pkg::stat_t  stat,
  output mpgr_pkg::cmd_t        cmd
);
  import mpgr_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_SCAN  = 3'd2;
  localparam logic [2:0] ST_GRD0  = 3'd3;
  localparam logic [2:0] ST_GRD1  = 3'd4;
  localparam logic [2:0] ST_GRD2  = 3'd5;
  localparam logic [2:0] ST_RD0   = 3'd6;
  localparam logic [2:0] ST_RD1   = 3'd7;

  logic [2:0] state, state_next;

  always_comb begin
    cmd = '0;
    state_next = state;
    in_ready = (state == ST_IDLE) && !res_full;
    case (state)
      ST_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: if (in_valid && in_ready) begin
        cmd.start = 1'b1;
        case (in_func)
          FUNC_FWD:  state_next = ST_SCAN;
          FUNC_GRAD: state_next = stat.no_windows ? ST_IDLE : ST_GRD0;
          FUNC_READ: state_next = ST_RD0;
          default:   state_next = ST_IDLE;
        endcase
      end
      ST_SCAN: begin
        if (stat.no_windows || stat.scan_done) state_next = ST_IDLE;
        else cmd.scan_step = 1'b1;
      end
      ST_GRD0: begin cmd.grad_read = 1'b1; state_next = ST_GRD1; end
      ST_GRD1: state_next = ST_GRD2;
      ST_GRD2: begin cmd.grad_write = 1'b1; state_next = ST_IDLE; end
      ST_RD0:  begin cmd.read_out = 1'b1; state_next = ST_RD1; end
      ST_RD1:  begin cmd.read_clear = 1'b1; state_next = ST_IDLE; end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLEAR;
    else state <= state_next;
  end

`ifndef ASSERT_OFF
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.start, cmd.scan_step, cmd.grad_write, cmd.read_clear, cmd.clear_step}))
    else $error("more than one command");
  a_wr_after_rd: assert property (@(posedge clk) disable iff (rst)
    cmd.grad_write |-> $past(state) == ST_GRD1)
    else $error("gradient write out of order");
  a_clear_after: assert property (@(posedge clk) disable iff (rst)
    cmd.read_clear |-> $past(cmd.read_out))
    else $error("readout clear without read");
`endif
endmodule
`default_nettype wire

@@ hw/rtl/max_pool_with_gradient_routing.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// max_pool_with_gradient_routing
// Max pooling forward pass with winner capture and gradient routing/readout.
// ----------------------------------------------------------------------------
//  channel   signals                          direction
//  request   valid, stall, func, sample       in
//  result    res_valid, res_stall, fields     out
//  config    cfg_write, cfg_index, cfg_data   in
// Forward request: an accept step, then one scan step per window candidate walked
// (window rows 0..r/S by window columns 0..c/S, clipped to the output size), one
// more step for each candidate whose window holds the sample, and a closing step;
// just accept and close when no window fits. Gradient: accept, winner read, sum
// read, write (just accept when no window fits); readout: accept, read, emit.
// After reset a clearing pass zeroes the gradient sums; stall holds.
// A pending result blocks new requests until it is taken.
module max_pool_with_gradient_routing (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               valid,
  output logic                    stall,
  input  wire logic [1:0]         func,
  input  wire logic signed [15:0] sample,
  output logic                    res_valid,
  input  wire logic               res_stall,
  output logic                    kind,
  output logic [1:0]              channel,
  output logic [4:0]              row,
  output logic [4:0]              col,
  output logic signed [19:0]      value,
  output logic                    last,
  input  wire logic               cfg_write,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [5:0]         cfg_data
);
  import mpgr_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic  ready;

  assign stall = !ready;

  mpgr_ctrl u_ctrl (
    .clk, .rst, .in_valid(valid), .in_func(func), .in_ready(ready),
    .res_full(res_valid), .stat, .cmd
  );

  mpgr_datapath u_dp (
    .clk, .rst, .cmd, .stat, .cfg_write, .cfg_index, .cfg_data, .func, .sample,
    .res_valid, .res_take(res_valid && !res_stall), .kind, .channel, .row, .col,
    .value, .last
  );
endmodule
`default_nettype wire

@@ tb/sv/pool_result_monitor.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pool_result_monitor
// Watches the request, result and register ports of the pooling block, keeps
// its own model of the pooling and gradient state and compares every result.
// ----------------------------------------------------------------------------
module pool_result_monitor (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid,
  input  logic               stall,
  input  logic [1:0]         func,
  input  logic signed [15:0] sample,
  input  logic               res_valid,
  input  logic               res_stall,
  input  logic               kind,
  input  logic [1:0]         channel,
  input  logic [4:0]         row,
  input  logic [4:0]         col,
  input  logic signed [19:0] value,
  input  logic               last,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [5:0]         cfg_data,
  output int                 mismatches,
  output int                 outstanding,
  output int                 results_seen
);
  import mpgr_pkg::*;

  localparam int MAP_CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int ALL_CELLS = MAX_CHANNELS * MAP_CELLS;
  localparam int SLOTS     = MAX_WINDOW * MAX_WIDTH;
  localparam int GRAD_HI   = (1 << (GRAD_BITS - 1)) - 1;
  localparam int GRAD_LO   = -GRAD_HI - 1;

  typedef struct packed {
    logic               kind;
    logic [1:0]         ch;
    logic [4:0]         r;
    logic [4:0]         c;
    logic signed [19:0] v;
    logic               last;
  } pool_out_t;

  pool_out_t pending_outputs[$];

  logic [5:0] width_reg, height_reg;
  logic [2:0] chan_reg, win_reg, step_reg;
  logic signed [15:0] part_val[SLOTS];
  int part_pos[SLOTS];
  int winner_at[ALL_CELLS];
  int grad_acc[ALL_CELLS];
  int fwd_at, bwd_at, rd_at;

  function automatic int fit(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int pooled_dim(int m, int k, int s);
    if (k > m) return 0;
    return (m - k) / s + 1;
  endfunction

  task automatic report_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("MISMATCH at %0t: %s", $time, what);
  endtask

  // Predict the outcome of one accepted request.
  task automatic route_and_pool(input logic [1:0] f, input logic signed [15:0] s);
    int w, h, c, k, st, ow, oh, total, pos, ch, rem, r, cc, slot, here, wp, sum;
    pool_out_t o;
    w = fit(width_reg, MAX_WIDTH);
    h = fit(height_reg, MAX_HEIGHT);
    c = fit(chan_reg, MAX_CHANNELS);
    k = fit(win_reg, MAX_WINDOW);
    st = fit(step_reg, MAX_WINDOW);
    ow = pooled_dim(w, k, st);
    oh = pooled_dim(h, k, st);
    if (f == FUNC_FWD) begin
      total = c * h * w;
      pos = (fwd_at >= total) ? 0 : fwd_at;
      fwd_at = (pos + 1 >= total) ? 0 : pos + 1;
      if (ow == 0 || oh == 0) return;
      ch = pos / (h * w);
      rem = pos % (h * w);
      r = rem / w;
      cc = rem % w;
      for (int i = 0; i < oh; i++) begin
        if (!(i * st <= r && r < i * st + k)) continue;
        for (int j = 0; j < ow; j++) begin
          if (!(j * st <= cc && cc < j * st + k)) continue;
          slot = (i % MAX_WINDOW) * MAX_WIDTH + j;
          here = r * MAX_WIDTH + cc;
          if (r == i * st && cc == j * st) begin
            part_val[slot] = s;
            part_pos[slot] = here;
          end else if (s > part_val[slot] ||
                       (s == part_val[slot] && cc < part_pos[slot] % MAX_WIDTH)) begin
            part_val[slot] = s;
            part_pos[slot] = here;
          end
          if (r == i * st + k - 1 && cc == j * st + k - 1) begin
            wp = part_pos[slot] % MAP_CELLS;
            winner_at[ch * MAP_CELLS + i * MAX_WIDTH + j] = wp;
            o.kind = 1'b0;
            o.ch = ch[1:0];
            o.r = 5'(wp / MAX_WIDTH);
            o.c = 5'(wp % MAX_WIDTH);
            o.v = 20'(part_val[slot]);
            o.last = (ch == c - 1 && i == oh - 1 && j == ow - 1);
            pending_outputs.push_back(o);
          end
        end
      end
    end else if (f == FUNC_GRAD) begin
      total = c * oh * ow;
      if (total == 0) return;
      pos = (bwd_at >= total) ? 0 : bwd_at;
      bwd_at = (pos + 1 >= total) ? 0 : pos + 1;
      ch = pos / (oh * ow);
      rem = pos % (oh * ow);
      wp = winner_at[ch * MAP_CELLS + (rem / ow) * MAX_WIDTH + rem % ow] % MAP_CELLS;
      sum = grad_acc[ch * MAP_CELLS + wp] + int'(s);
      if (sum > GRAD_HI) sum = GRAD_HI;
      if (sum < GRAD_LO) sum = GRAD_LO;
      grad_acc[ch * MAP_CELLS + wp] = sum;
    end else if (f == FUNC_READ) begin
      total = c * h * w;
      pos = (rd_at >= total) ? 0 : rd_at;
      rd_at = (pos + 1 >= total) ? 0 : pos + 1;
      ch = pos / (h * w);
      rem = pos % (h * w);
      r = rem / w;
      cc = rem % w;
      here = ch * MAP_CELLS + r * MAX_WIDTH + cc;
      o.kind = 1'b1;
      o.ch = ch[1:0];
      o.r = r[4:0];
      o.c = cc[4:0];
      o.v = 20'(grad_acc[here]);
      o.last = (pos + 1 == total);
      pending_outputs.push_back(o);
      grad_acc[here] = 0;
    end
  endtask

  always @(posedge clk) begin
    pool_out_t got, want;
    if (rst) begin
      width_reg = 6'd32;
      height_reg = 6'd32;
      chan_reg = 3'd4;
      win_reg = 3'd2;
      step_reg = 3'd2;
      fwd_at = 0;
      bwd_at = 0;
      rd_at = 0;
      for (int i = 0; i < ALL_CELLS; i++) begin
        grad_acc[i] = 0;
        winner_at[i] = 0;
      end
      for (int i = 0; i < SLOTS; i++) begin
        part_val[i] = '0;
        part_pos[i] = 0;
      end
      pending_outputs.delete();
      mismatches = 0;
      results_seen = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_WIDTH:  width_reg = cfg_data;
          REG_HEIGHT: height_reg = cfg_data;
          REG_CHAN:   chan_reg = cfg_data[2:0];
          REG_WIN:    win_reg = cfg_data[2:0];
          REG_STEP:   step_reg = cfg_data[2:0];
          default: ;
        endcase
        if (cfg_index <= REG_STEP) begin
          fwd_at = 0;
          bwd_at = 0;
          rd_at = 0;
        end
      end
      if (valid && !stall) route_and_pool(func, sample);
      if (res_valid && !res_stall) begin
        results_seen++;
        got = '{kind, channel, row, col, value, last};
        if (pending_outputs.size() == 0) begin
          report_mismatch($sformatf("unexpected result %p", got));
        end else begin
          want = pending_outputs.pop_front();
          if (got != want) report_mismatch($sformatf("got %p want %p", got, want));
        end
      end
    end
    outstanding = pending_outputs.size();
  end

endmodule

@@ tb/sv/max_pool_with_gradient_routing_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_pool_with_gradient_routing_test
// Drives forward, gradient and readout requests through many map settings
// under random idling and a long result hold-off; the monitor checks results.
// ----------------------------------------------------------------------------
module max_pool_with_gradient_routing_test;
  import mpgr_pkg::*;

  // Unused function code: the block must ignore it.
  localparam logic [1:0] FUNC_NONE = 2'd3;
  // Request budget for the whole run; sends past it are dropped.
  localparam int ITEM_TOTAL = 1050;

  logic               clk;
  logic               rst;
  logic               valid;
  logic               stall;
  logic [1:0]         func;
  logic signed [15:0] sample;
  logic               res_valid;
  logic               res_stall;
  logic               kind;
  logic [1:0]         channel;
  logic [4:0]         row;
  logic [4:0]         col;
  logic signed [19:0] value;
  logic               last;
  logic               cfg_write;
  logic [2:0]         cfg_index;
  logic [5:0]         cfg_data;

  int mismatches, outstanding, results_seen;
  int requests_sent;
  int settings_run;
  int send_idle_pct, recv_stall_pct;
  bit hold_done;
  int hold_left;

  max_pool_with_gradient_routing dut (
    .clk, .rst, .valid, .stall, .func, .sample,
    .res_valid, .res_stall, .kind, .channel, .row, .col, .value, .last,
    .cfg_write, .cfg_index, .cfg_data
  );

  pool_result_monitor monitor (
    .clk, .rst, .valid, .stall, .func, .sample,
    .res_valid, .res_stall, .kind, .channel, .row, .col, .value, .last,
    .cfg_write, .cfg_index, .cfg_data,
    .mismatches, .outstanding, .results_seen
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Result side: random stalls, plus one long hold-off once traffic is going
  // so the block backs up and stalls its requests.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else if (!hold_done && requests_sent >= 300) begin
      hold_done = 1'b1;
      hold_left = 500;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  function automatic int fit(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int pooled_dim(int m, int k, int s);
    if (k > m) return 0;
    return (m - k) / s + 1;
  endfunction

  // Offer one request; valid stays high after acceptance until the next call
  // either drives a new request or idles.
  task automatic send(input logic [1:0] f, input logic signed [15:0] s);
    if (requests_sent >= ITEM_TOTAL) return;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      valid <= 1'b0;
      @(negedge clk);
    end
    valid <= 1'b1;
    func <= f;
    sample <= s;
    do @(posedge clk); while (stall);
    if (f != FUNC_NONE) requests_sent++;
  endtask

  // Drop valid and wait until every result is back, then let the block settle
  // in case a trailing gradient request is still being written.
  task automatic wait_idle();
    @(negedge clk);
    valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (64) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [5:0] data);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic configure(input int w, input int h, input int c, input int k, input int s);
    wait_idle();
    write_reg(REG_WIDTH, 6'(w));
    write_reg(REG_HEIGHT, 6'(h));
    write_reg(REG_CHAN, 6'(c));
    write_reg(REG_WIN, 6'(k));
    write_reg(REG_STEP, 6'(s));
    // An unknown index must neither change a register nor rewind the passes.
    if ($urandom_range(3) == 0) write_reg(3'($urandom_range(5, 7)), 6'($urandom));
    case (settings_run % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
      default: begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
    settings_run++;
  endtask

  function automatic logic signed [15:0] pick_sample(bit narrow);
    if (narrow) return 16'($urandom_range(0, 2));
    return 16'($urandom);
  endfunction

  // One setting: full forward pass(es) so every winner exists, gradient
  // pass(es), full readout, then in gmode 0 a broken tail of partial passes.
  task automatic run_setting(input int w, input int h, input int c, input int k, input int s,
                             input int gmode);
    int ew, eh, ec, cells, windows, passes;
    bit narrow;
    configure(w, h, c, k, s);
    ew = fit(w, MAX_WIDTH);
    eh = fit(h, MAX_HEIGHT);
    ec = fit(c & 7, MAX_CHANNELS);
    cells = ec * eh * ew;
    windows = ec * pooled_dim(eh, fit(k & 7, MAX_WINDOW), fit(s & 7, MAX_WINDOW))
                 * pooled_dim(ew, fit(k & 7, MAX_WINDOW), fit(s & 7, MAX_WINDOW));
    narrow = ($urandom_range(2) == 0);
    passes = (gmode != 0) ? 1 : $urandom_range(1, 2);
    for (int p = 0; p < passes; p++)
      for (int n = 0; n < cells; n++) begin
        if ($urandom_range(99) < 4) send(FUNC_NONE, 16'($urandom));
        send(FUNC_FWD, pick_sample(narrow));
      end
    if (gmode != 0) passes = 18;
    else passes = $urandom_range(1, 2);
    for (int p = 0; p < passes; p++)
      for (int n = 0; n < ((windows == 0) ? 2 : windows); n++) begin
        if (gmode == 1) send(FUNC_GRAD, 16'sh7fff);
        else if (gmode == 2) send(FUNC_GRAD, -16'sh8000);
        else send(FUNC_GRAD, 16'($urandom));
      end
    for (int n = 0; n < cells; n++) send(FUNC_READ, 16'($urandom));
    if (gmode == 0) begin
      repeat ($urandom_range(0, cells / 2)) send(FUNC_FWD, pick_sample(narrow));
      repeat ($urandom_range(0, 3)) send(FUNC_READ, 16'($urandom));
    end
  endtask

  initial begin
    rst = 1'b1;
    valid = 1'b0;
    func = FUNC_FWD;
    sample = '0;
    res_stall = 1'b0;
    cfg_write = 1'b0;
    cfg_index = REG_WIDTH;
    cfg_data = '0;
    requests_sent = 0;
    settings_run = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_done = 1'b0;
    hold_left = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // Hold off through the clearing pass that follows reset.
    repeat (4200) @(negedge clk);

    // Directed: 2x2 map, one 2x2 window. All-equal samples keep the first;
    // then two equal maxima where the earlier column must win.
    configure(2, 2, 1, 2, 2);
    for (int n = 0; n < 4; n++) send(FUNC_FWD, 16'sd5);
    send(FUNC_GRAD, 16'sh7fff);
    for (int n = 0; n < 4; n++) send(FUNC_READ, '0);
    send(FUNC_FWD, 16'sd0);
    send(FUNC_FWD, 16'sd3);
    send(FUNC_FWD, 16'sd3);
    send(FUNC_FWD, 16'sd0);
    send(FUNC_NONE, 16'sh7fff);
    send(FUNC_GRAD, -16'sh8000);
    for (int n = 0; n < 4; n++) send(FUNC_READ, 16'shffff);
    // Window wider than the map: no windows, gradients ignored.
    configure(1, 1, 1, 3, 1);
    send(FUNC_FWD, -16'sh8000);
    send(FUNC_GRAD, 16'sh1234);
    send(FUNC_READ, '0);

    // Random part, opening with the extreme settings: widest map with all
    // channels, tallest map, and gradient saturation both ways.
    run_setting(63, 0, 4, 2, 2, 0);
    run_setting(0, 32, 1, 1, 1, 0);
    run_setting(1, 1, 1, 1, 1, 1);
    run_setting(1, 1, 0, 0, 0, 2);
    while (requests_sent < ITEM_TOTAL)
      run_setting($urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(0, 7),
                  $urandom_range(0, 7), $urandom_range(0, 7), 0);

    @(negedge clk);
    valid <= 1'b0;
    for (int guard = 0; guard < 20000 && outstanding != 0; guard++) @(negedge clk);
    repeat (64) @(negedge clk);
    $display("Covered %0d requests and %0d results across %0d register settings,",
             requests_sent, results_seen, settings_run);
    $display("including saturation, ties, oversized windows and a long result hold-off.");
    if (mismatches == 0 && outstanding == 0) begin
      $display("max_pool_with_gradient_routing verification clean");
    end else begin
      $display("max_pool_with_gradient_routing verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("max_pool_with_gradient_routing verification failed");
    $finish;
  end

endmodule
